[sv/sphuv_pkg.sv]
package sphuv_pkg;

    // Datapath widths that the fixed field formats settle.
    localparam int MAG_W        = 30;
    localparam int ROOT_W       = 31;
    localparam int SQRT_W       = 62;
    localparam int ANG_W        = 32;
    localparam int CR_W         = 34;
    localparam int CORDIC_STEPS = 28;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;

    // One in Q30 (a cosine of one, or an angle of pi).
    localparam logic [ROOT_W-1:0] ANG_ONE  = 31'h4000_0000;
    localparam logic [ROOT_W-1:0] ANG_HALF = 31'h2000_0000;

    // atan(2^-i)/pi in Q30.
    localparam logic [ANG_W-1:0] ATAN_PI_Q30 [CORDIC_STEPS] = '{
        32'd268435456, 32'd158466703, 32'd83729454, 32'd42502378, 32'd21333666,
        32'd10677233, 32'd5339919, 32'd2670123, 32'd1335082, 32'd667543,
        32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430,
        32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81,
        32'd41, 32'd20, 32'd10, 32'd5, 32'd3
    };

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
    } vertex_t;

    typedef struct packed {
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } texcoord_t;

    // Per-vertex data that rides alongside the radius computation.
    typedef struct packed {
        logic [MAG_W-1:0] mag_z;
        logic [MAG_W-1:0] mag_y;
        logic             neg_z;
        logic             neg_y;
    } side_t;

endpackage

[sv/sphuv_front.sv]
module sphuv_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  sphuv_pkg::vertex_t            vert,
    input  logic signed [31:0]            center_x,
    input  logic signed [31:0]            center_y,
    input  logic signed [31:0]            center_z,
    output logic                          out_valid,
    output logic [sphuv_pkg::SQRT_W-1:0]  sum_sq,
    output sphuv_pkg::side_t              side
);
    import sphuv_pkg::*;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [32:0] dx, dy, dz, ndx, ndy, ndz;
    logic [31:0] ax1_next, ay1_next, az1_next;
    logic [31:0] ax1_reg, ay1_reg, az1_reg;
    logic        ny1_reg, nz1_reg;
    logic [31:0] m_max;
    logic [31:0] sx, sy, sz;
    logic [MAG_W-1:0] ax2_reg, ay2_reg, az2_reg;
    logic        ny2_reg, nz2_reg;
    logic [59:0] sqx, sqy, sqz;
    logic [59:0] sqx3_reg, sqy3_reg, sqz3_reg;
    logic [MAG_W-1:0] ay3_reg, az3_reg;
    logic        ny3_reg, nz3_reg;
    logic [SQRT_W-1:0] sum_next, sum_reg;
    side_t       side_reg;

    // Stage 1: differences to the center as sign and magnitude.
    always_comb
    begin
        dx  = {vert.vert_x[31], vert.vert_x} - {center_x[31], center_x};
        dy  = {vert.vert_y[31], vert.vert_y} - {center_y[31], center_y};
        dz  = {vert.vert_z[31], vert.vert_z} - {center_z[31], center_z};
        ndx = -dx;
        ndy = -dy;
        ndz = -dz;
        ax1_next = dx[32] ? ndx[31:0] : dx[31:0];
        ay1_next = dy[32] ? ndy[31:0] : dy[31:0];
        az1_next = dz[32] ? ndz[31:0] : dz[31:0];
    end

    // Stage 2: common right shift so that the largest magnitude is below 2^30.
    always_comb
    begin
        m_max = ax1_reg;
        if (ay1_reg > m_max)
        begin
            m_max = ay1_reg;
        end
        if (az1_reg > m_max)
        begin
            m_max = az1_reg;
        end
        if (m_max[31])
        begin
            sx = ax1_reg >> 2;
            sy = ay1_reg >> 2;
            sz = az1_reg >> 2;
        end
        else if (m_max[30])
        begin
            sx = ax1_reg >> 1;
            sy = ay1_reg >> 1;
            sz = az1_reg >> 1;
        end
        else
        begin
            sx = ax1_reg;
            sy = ay1_reg;
            sz = az1_reg;
        end
    end

    // Stage 3: squares; stage 4: their sum.
    assign sqx      = ax2_reg * ax2_reg;
    assign sqy      = ay2_reg * ay2_reg;
    assign sqz      = az2_reg * az2_reg;
    assign sum_next = SQRT_W'(sqx3_reg) + SQRT_W'(sqy3_reg) + SQRT_W'(sqz3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax1_reg  <= ax1_next;
        ay1_reg  <= ay1_next;
        az1_reg  <= az1_next;
        ny1_reg  <= dy[32];
        nz1_reg  <= dz[32];
        ax2_reg  <= sx[MAG_W-1:0];
        ay2_reg  <= sy[MAG_W-1:0];
        az2_reg  <= sz[MAG_W-1:0];
        ny2_reg  <= ny1_reg;
        nz2_reg  <= nz1_reg;
        sqx3_reg <= sqx;
        sqy3_reg <= sqy;
        sqz3_reg <= sqz;
        ay3_reg  <= ay2_reg;
        az3_reg  <= az2_reg;
        ny3_reg  <= ny2_reg;
        nz3_reg  <= nz2_reg;
        sum_reg  <= sum_next;
        side_reg.mag_z <= az3_reg;
        side_reg.mag_y <= ay3_reg;
        side_reg.neg_z <= nz3_reg;
        side_reg.neg_y <= ny3_reg;
    end

    assign out_valid = v4_reg;
    assign sum_sq    = sum_reg;
    assign side      = side_reg;

endmodule

[sv/sphuv_isqrt.sv]
module sphuv_isqrt #(
    parameter int IN_W = 62,
    parameter int SB_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [IN_W-1:0]      radicand,
    input  logic [SB_W-1:0]      in_side,
    output logic                 out_valid,
    output logic [IN_W/2-1:0]    root,
    output logic [SB_W-1:0]      out_side
);
    localparam int STAGES = IN_W / 2;

    logic [STAGES-1:0] vld_reg;
    logic [IN_W-1:0]   n_reg   [STAGES];
    logic [IN_W-1:0]   res_reg [STAGES];
    logic [SB_W-1:0]   sb_reg  [STAGES];

    // One result bit per stage, most significant first.
    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        logic [IN_W-1:0] n_in, res_in, bit_c, trial, n_next, res_next;
        logic [SB_W-1:0] sb_in;
        logic            vld_in;

        if (j == 0)
        begin : g_first
            assign n_in   = radicand;
            assign res_in = '0;
            assign sb_in  = in_side;
            assign vld_in = in_valid;
        end
        else
        begin : g_rest
            assign n_in   = n_reg[j-1];
            assign res_in = res_reg[j-1];
            assign sb_in  = sb_reg[j-1];
            assign vld_in = vld_reg[j-1];
        end

        assign bit_c = {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2 * j);
        assign trial = res_in + bit_c;

        always_comb
        begin
            if (n_in >= trial)
            begin
                n_next   = n_in - trial;
                res_next = (res_in >> 1) + bit_c;
            end
            else
            begin
                n_next   = n_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[j]   <= n_next;
            res_reg[j] <= res_next;
            sb_reg[j]  <= sb_in;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign root      = res_reg[STAGES-1][IN_W/2-1:0];
    assign out_side  = sb_reg[STAGES-1];

endmodule

[sv/sphuv_div.sv]
module sphuv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [sphuv_pkg::MAG_W-1:0]   mag,
    input  logic [sphuv_pkg::ROOT_W-1:0]  divisor,
    input  logic                          neg,
    output logic                          out_valid,
    output logic [sphuv_pkg::ROOT_W-1:0]  quot,
    output logic                          out_neg
);
    import sphuv_pkg::*;

    localparam int REM_W = ROOT_W + 1;

    logic [ROOT_W-1:0] vld_reg;
    logic [REM_W-1:0]  rem_reg [ROOT_W];
    logic [ROOT_W-1:0] div_reg [ROOT_W];
    logic [ROOT_W-1:0] q_reg   [ROOT_W];
    logic [ROOT_W-1:0] neg_reg;

    // Restoring division of mag * 2^30 by the radius, one quotient bit per stage.
    // The magnitude never exceeds the radius, so the quotient fits in 31 bits.
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        logic [REM_W-1:0]  rem_in, shifted, rem_next;
        logic [ROOT_W-1:0] div_in, q_in;
        logic              nbit, neg_in, vld_in, ge;

        if (j == 0)
        begin : g_first
            assign rem_in = {3'b000, mag[MAG_W-1:1]};
            assign nbit   = mag[0];
            assign div_in = divisor;
            assign q_in   = '0;
            assign neg_in = neg;
            assign vld_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign nbit   = 1'b0;
            assign div_in = div_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign neg_in = neg_reg[j-1];
            assign vld_in = vld_reg[j-1];
        end

        assign shifted  = {rem_in[REM_W-2:0], nbit};
        assign ge       = shifted >= {1'b0, div_in};
        assign rem_next = ge ? shifted - {1'b0, div_in} : shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            div_reg[j] <= div_in;
            q_reg[j]   <= {q_in[ROOT_W-2:0], ge};
            neg_reg[j] <= neg_in;
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign quot      = q_reg[ROOT_W-1];
    assign out_neg   = neg_reg[ROOT_W-1];

endmodule

[sv/sphuv_acos.sv]
module sphuv_acos #(
    parameter int UV_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [sphuv_pkg::ROOT_W-1:0]  quot,
    input  logic                          neg,
    output logic                          out_valid,
    output logic [16:0]                   tex
);
    import sphuv_pkg::*;

    localparam int                OUT_SHIFT = 30 - UV_FRAC_BITS;
    localparam logic [ANG_W-1:0]  ROUND_ADD = ANG_W'(1) << (29 - UV_FRAC_BITS);
    localparam logic [SQRT_W-1:0] ONE_SQ    = SQRT_W'(1) << 60;

    logic              va_reg, vb_reg, vo_reg;
    logic [ROOT_W-1:0] c_next, ca_reg, cb_reg;
    logic [SQRT_W-1:0] csq_next, csqa_reg, radb_reg;
    logic              nega_reg, negb_reg;
    logic              sq_valid;
    logic [ROOT_W-1:0] w_root;
    logic [ROOT_W:0]   sq_side;

    logic [CORDIC_STEPS-1:0] cv_reg, half_reg, zero_reg, cneg_reg;
    logic signed [CR_W-1:0]  x_reg [CORDIC_STEPS];
    logic signed [CR_W-1:0]  y_reg [CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg [CORDIC_STEPS];

    logic signed [ANG_W-1:0] z_fin;
    logic [ROOT_W-1:0]       a_clamp, a_sel, angle;
    logic [ANG_W-1:0]        rsum, rshift;
    logic [16:0]             tex_next, tex_reg;

    // Cosine clamp and its square.
    assign c_next   = (quot > ANG_ONE) ? ANG_ONE : quot;
    assign csq_next = c_next * c_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ca_reg   <= c_next;
        csqa_reg <= csq_next;
        nega_reg <= neg;
        cb_reg   <= ca_reg;
        radb_reg <= ONE_SQ - csqa_reg;
        negb_reg <= nega_reg;
    end

    // Sine from sqrt(1 - c^2).
    sphuv_isqrt #(
        .IN_W (SQRT_W),
        .SB_W (ROOT_W + 1)
    ) u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vb_reg),
        .radicand  (radb_reg),
        .in_side   ({cb_reg, negb_reg}),
        .out_valid (sq_valid),
        .root      (w_root),
        .out_side  (sq_side)
    );

    // Vectoring CORDIC on (c, w), angle kept in units of pi.
    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_cordic
        logic signed [CR_W-1:0]  x_in, y_in, xs, ys;
        logic signed [ANG_W-1:0] z_in;
        logic                    v_in, h_in, zr_in, n_in;

        if (j == 0)
        begin : g_first
            assign x_in  = CR_W'(sq_side[ROOT_W:1]);
            assign y_in  = CR_W'(w_root);
            assign z_in  = '0;
            assign v_in  = sq_valid;
            assign h_in  = (sq_side[ROOT_W:1] == '0);
            assign zr_in = (sq_side[ROOT_W:1] >= ANG_ONE) || (w_root == '0);
            assign n_in  = sq_side[0];
        end
        else
        begin : g_rest
            assign x_in  = x_reg[j-1];
            assign y_in  = y_reg[j-1];
            assign z_in  = z_reg[j-1];
            assign v_in  = cv_reg[j-1];
            assign h_in  = half_reg[j-1];
            assign zr_in = zero_reg[j-1];
            assign n_in  = cneg_reg[j-1];
        end

        assign xs = x_in >>> j;
        assign ys = y_in >>> j;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[j] <= 1'b0;
            end
            else
            begin
                cv_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (!y_in[CR_W-1])
            begin
                x_reg[j] <= x_in + ys;
                y_reg[j] <= y_in - xs;
                z_reg[j] <= z_in + $signed(ATAN_PI_Q30[j]);
            end
            else
            begin
                x_reg[j] <= x_in - ys;
                y_reg[j] <= y_in + xs;
                z_reg[j] <= z_in - $signed(ATAN_PI_Q30[j]);
            end
            half_reg[j] <= h_in;
            zero_reg[j] <= zr_in;
            cneg_reg[j] <= n_in;
        end
    end

    // Clamp, special cases, reflection for negative cosines, rounding.
    always_comb
    begin
        z_fin = z_reg[CORDIC_STEPS-1];
        if (z_fin[ANG_W-1])
        begin
            a_clamp = '0;
        end
        else if (z_fin > $signed({1'b0, ANG_HALF}))
        begin
            a_clamp = ANG_HALF;
        end
        else
        begin
            a_clamp = z_fin[ROOT_W-1:0];
        end
        if (half_reg[CORDIC_STEPS-1])
        begin
            a_sel = ANG_HALF;
        end
        else if (zero_reg[CORDIC_STEPS-1])
        begin
            a_sel = '0;
        end
        else
        begin
            a_sel = a_clamp;
        end
        angle    = cneg_reg[CORDIC_STEPS-1] ? ANG_ONE - a_sel : a_sel;
        rsum     = {1'b0, angle} + ROUND_ADD;
        rshift   = rsum >> OUT_SHIFT;
        tex_next = rshift[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= cv_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tex_reg <= tex_next;
    end

    assign out_valid = vo_reg;
    assign tex       = tex_reg;

endmodule

[sv/spherical_uv_projection.sv]
// Each start transfer comes out as one done strobe at the end of the pipeline.
// Throughput: one vertex per clock cycle; busy is never raised.
// The path is a fixed pipeline: 4 front stages, a 31-stage radius square root,
// a 31-stage divider, and per coordinate 2 + 31 + 28 + 1 stages of sine and CORDIC.
// Reset (rst_n low, asynchronous) clears the center registers and all valid bits.
// The receiver cannot stall: each result is shown for exactly one cycle.
module spherical_uv_projection #(
    parameter int UV_FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sphuv_pkg::vertex_t    vert,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output logic                  done,
    output sphuv_pkg::texcoord_t  tex
);
    import sphuv_pkg::*;

    logic signed [31:0] center_x_reg, center_y_reg, center_z_reg;
    logic               fr_valid, rt_valid, dv_valid;
    logic [SQRT_W-1:0]  sum_sq;
    side_t              fr_side, rt_side;
    logic [ROOT_W-1:0]  r_root, r_div;
    logic [ROOT_W-1:0]  quot_z, quot_y;
    logic               neg_z, neg_y;
    logic [16:0]        tex_u, tex_v;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_CENTER_Z: center_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    sphuv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .vert      (vert),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .out_valid (fr_valid),
        .sum_sq    (sum_sq),
        .side      (fr_side)
    );

    sphuv_isqrt #(
        .IN_W (SQRT_W),
        .SB_W ($bits(side_t))
    ) u_radius (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .radicand  (sum_sq),
        .in_side   (fr_side),
        .out_valid (rt_valid),
        .root      (r_root),
        .out_side  (rt_side)
    );

    // A vertex at the center has radius floored to one.
    assign r_div = (r_root == '0) ? ROOT_W'(1) : r_root;

    sphuv_div u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .mag       (rt_side.mag_z),
        .divisor   (r_div),
        .neg       (rt_side.neg_z),
        .out_valid (dv_valid),
        .quot      (quot_z),
        .out_neg   (neg_z)
    );

    sphuv_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .mag       (rt_side.mag_y),
        .divisor   (r_div),
        .neg       (rt_side.neg_y),
        .out_valid (),
        .quot      (quot_y),
        .out_neg   (neg_y)
    );

    sphuv_acos #(
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_acos_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .quot      (quot_z),
        .neg       (neg_z),
        .out_valid (done),
        .tex       (tex_u)
    );

    sphuv_acos #(
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_acos_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .quot      (quot_y),
        .neg       (neg_y),
        .out_valid (),
        .tex       (tex_v)
    );

    assign tex.tex_u = tex_u;
    assign tex.tex_v = tex_v;

endmodule

[sv/sphuv_checker.sv]
module sphuv_checker #(
    parameter int LATENCY = 128
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    localparam int CNT_W = $clog2(LATENCY + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             warm;

    // Cycles since reset, saturating once the pipeline has filled.
    assign warm     = (cnt_reg == CNT_W'(LATENCY));
    assign cnt_next = warm ? cnt_reg : cnt_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // The block takes a vertex in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> !busy)
        else $error("busy raised");

    // Every transfer yields exactly one result a fixed number of cycles later.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> (done == $past(start && !busy, LATENCY)))
        else $error("result strobe does not match a transfer");

    // Nothing comes out before the pipeline could have filled.
    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !warm |-> !done)
        else $error("result strobe too soon after reset");

endmodule

bind spherical_uv_projection sphuv_checker #(.LATENCY(128)) u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
